### src/thermal_head_strobe_sequencer_unit_macros.svh
// Assertion macros shared by the strobe sequencer RTL.
`ifndef THERMAL_HEAD_STROBE_SEQUENCER_UNIT_MACROS_SVH
`define THERMAL_HEAD_STROBE_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define THSQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define THSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/thsq_pkg.sv
// ---------------------------------------------------------------------------
// thsq_pkg
// Commands, phase numbers and field widths of the strobe sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package thsq_pkg;

	localparam int CMD_W  = 2;
	localparam int STEP_W = 16;
	localparam int IDX_W  = 6;
	localparam int DATA_W = 8;
	localparam int PH_W   = 3;
	localparam int BANK_W = 2;

	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

	localparam logic [PH_W-1:0] PHASE_COUNT = 3'd6;
	localparam logic [PH_W-1:0] PH_STREAM   = 3'd0;
	localparam logic [PH_W-1:0] PH_BANK2    = 3'd2;
	localparam logic [PH_W-1:0] PH_MOTOR    = 3'd3;
	localparam logic [PH_W-1:0] PH_BANK3    = 3'd4;

	localparam logic [BANK_W-1:0] BANK_OFF = 2'd0;
	localparam logic [BANK_W-1:0] BANK_1   = 2'd1;
	localparam logic [BANK_W-1:0] BANK_2   = 2'd2;
	localparam logic [BANK_W-1:0] BANK_3   = 2'd3;

endpackage

`default_nettype wire

### src/thsq_line_ram.sv
// ---------------------------------------------------------------------------
// thsq_line_ram
// Dot-line buffer: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thsq_line_ram #(
	parameter int DEPTH = 48,
	parameter int AW    = 6
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [AW-1:0]              waddr,
	input  wire logic [thsq_pkg::DATA_W-1:0] wdata,
	input  wire logic                       re,
	input  wire logic [AW-1:0]              raddr,
	output logic      [thsq_pkg::DATA_W-1:0] rdata
);

	logic [thsq_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### src/thermal_head_strobe_sequencer_unit.sv
// A write or start request is accepted and gives no result.
// A tick other than the line tick gives its single result in the cycle after acceptance.
// A line tick gives LINE_BYTES results via the stream flag, RAM read data and output
// registers, one per cycle unless out_stall holds them; no new input is taken meanwhile.
// Reset (arst_n low, asynchronous) stops the sequencer, inhibits the motor and turns the
// strobes off (state only); line RAM is not cleared, holds nothing valid until written.
// ---------------------------------------------------------------------------
// thermal_head_strobe_sequencer_unit
// Tick-driven phase sequencer for a thermal head and its paper stepper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "thermal_head_strobe_sequencer_unit_macros.svh"

module thermal_head_strobe_sequencer_unit #(
	parameter int LINE_BYTES = 48
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [thsq_pkg::CMD_W-1:0]  command,
	input  wire logic [thsq_pkg::STEP_W-1:0] step_count,
	input  wire logic [thsq_pkg::IDX_W-1:0]  byte_index,
	input  wire logic [thsq_pkg::DATA_W-1:0] line_byte,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             motor_inhibit,
	output logic                             motor_phase,
	output logic [thsq_pkg::BANK_W-1:0]      strobe_bank,
	output logic [thsq_pkg::DATA_W-1:0]      head_data,
	output logic                             head_data_valid,
	output logic                             latch_pulse,
	output logic                             running,
	output logic                             last
);

	localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(LINE_BYTES - 1);
	localparam logic [thsq_pkg::IDX_W:0] LINE_LIMIT = (thsq_pkg::IDX_W + 1)'(LINE_BYTES);

	// sequencer state
	logic [thsq_pkg::PH_W-1:0]   phase_cnt_q;
	logic                        run_q;
	logic [thsq_pkg::STEP_W-1:0] steps_q;
	logic                        lvl_q;
	logic [thsq_pkg::BANK_W-1:0] bank_q;
	logic                        inhibit_q;

	logic [thsq_pkg::PH_W-1:0]   n_phase;
	logic                        n_run;
	logic [thsq_pkg::STEP_W-1:0] n_steps;
	logic                        n_lvl;
	logic [thsq_pkg::BANK_W-1:0] n_bank;
	logic                        n_inhibit;
	logic                        single_res;
	logic                        start_stream;
	logic                        mem_we;
	logic [thsq_pkg::PH_W-1:0]   ph_inc;
	logic [thsq_pkg::PH_W-1:0]   ph_nxt;
	logic [thsq_pkg::STEP_W-1:0] steps_dec;

	// line streaming
	logic          stream_q;
	logic [AW-1:0] idx_q;
	logic          pend_s1;
	logic          pend_last_s1;
	logic          rd_en;
	logic [thsq_pkg::DATA_W-1:0] rdata;

	// output register
	logic                        out_valid_q;
	logic                        inhibit_out_q;
	logic                        phase_out_q;
	logic [thsq_pkg::BANK_W-1:0] bank_out_q;
	logic [thsq_pkg::DATA_W-1:0] data_out_q;
	logic                        dvalid_out_q;
	logic                        latch_out_q;
	logic                        run_out_q;
	logic                        last_out_q;

	logic out_free;
	logic in_acc;
	logic byte_load;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = stream_q || pend_s1 || !out_free;
	assign in_acc    = in_valid && !in_stall;
	assign rd_en     = stream_q && (!pend_s1 || out_free);
	assign byte_load = pend_s1 && out_free;

	assign ph_inc    = phase_cnt_q + 3'd1;
	assign ph_nxt    = (ph_inc >= thsq_pkg::PHASE_COUNT) ? thsq_pkg::PH_STREAM : ph_inc;
	assign steps_dec = (steps_q != '0) ? (steps_q - 16'd1) : steps_q;

	always_comb begin
		n_phase      = phase_cnt_q;
		n_run        = run_q;
		n_steps      = steps_q;
		n_lvl        = lvl_q;
		n_bank       = bank_q;
		n_inhibit    = inhibit_q;
		single_res   = 1'b0;
		start_stream = 1'b0;
		mem_we       = 1'b0;
		if (in_acc) begin
			unique case (command)
				thsq_pkg::CMD_START: begin
					n_steps = step_count;
					n_run   = 1'b1;
				end
				thsq_pkg::CMD_WRITE: begin
					mem_we = ({1'b0, byte_index} < LINE_LIMIT);
				end
				thsq_pkg::CMD_TICK: begin
					if (!run_q) begin
						n_inhibit  = 1'b1;
						n_bank     = thsq_pkg::BANK_OFF;
						n_phase    = thsq_pkg::PHASE_COUNT;
						single_res = 1'b1;
					end else begin
						n_phase    = ph_nxt;
						single_res = 1'b1;
						case (ph_nxt)
							thsq_pkg::PH_STREAM: begin
								n_inhibit    = 1'b0;
								n_lvl        = !lvl_q;
								n_bank       = thsq_pkg::BANK_1;
								single_res   = 1'b0;
								start_stream = 1'b1;
							end
							thsq_pkg::PH_BANK2: n_bank = thsq_pkg::BANK_2;
							thsq_pkg::PH_MOTOR: n_lvl  = !lvl_q;
							thsq_pkg::PH_BANK3: begin
								n_bank  = thsq_pkg::BANK_3;
								n_steps = steps_dec;
								if (steps_dec == '0) begin
									n_run = 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_cnt_q <= '0;
			run_q       <= 1'b0;
			steps_q     <= '0;
			lvl_q       <= 1'b0;
			bank_q      <= thsq_pkg::BANK_OFF;
			inhibit_q   <= 1'b1;
		end else begin
			phase_cnt_q <= n_phase;
			run_q       <= n_run;
			steps_q     <= n_steps;
			lvl_q       <= n_lvl;
			bank_q      <= n_bank;
			inhibit_q   <= n_inhibit;
		end
	end

	// issue one RAM read per free output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_q     <= 1'b0;
			idx_q        <= '0;
			pend_s1      <= 1'b0;
			pend_last_s1 <= 1'b0;
		end else begin
			if (start_stream) begin
				stream_q <= 1'b1;
				idx_q    <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == LAST_IDX) begin
					stream_q <= 1'b0;
				end
			end
			if (rd_en) begin
				pend_s1      <= 1'b1;
				pend_last_s1 <= (idx_q == LAST_IDX);
			end else if (byte_load) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	thsq_line_ram #(
		.DEPTH(LINE_BYTES),
		.AW   (AW)
	) u_line_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(byte_index[AW-1:0]),
		.wdata(line_byte),
		.re   (rd_en),
		.raddr(idx_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (single_res || byte_load) begin
			out_valid_q <= 1'b1;
		end else if (out_free) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (single_res) begin
			inhibit_out_q <= n_inhibit;
			phase_out_q   <= n_lvl;
			bank_out_q    <= n_bank;
			data_out_q    <= '0;
			dvalid_out_q  <= 1'b0;
			latch_out_q   <= 1'b0;
			run_out_q     <= n_run;
			last_out_q    <= 1'b1;
		end else if (byte_load) begin
			inhibit_out_q <= inhibit_q;
			phase_out_q   <= lvl_q;
			bank_out_q    <= bank_q;
			data_out_q    <= rdata;
			dvalid_out_q  <= 1'b1;
			latch_out_q   <= pend_last_s1;
			run_out_q     <= run_q;
			last_out_q    <= pend_last_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign motor_inhibit   = inhibit_out_q;
	assign motor_phase     = phase_out_q;
	assign strobe_bank     = bank_out_q;
	assign head_data       = data_out_q;
	assign head_data_valid = dvalid_out_q;
	assign latch_pulse     = latch_out_q;
	assign running         = run_out_q;
	assign last            = last_out_q;

	`THSQ_ASSERT_IMPLY(a_phase_range, clk, arst_n, 1'b1, phase_cnt_q <= thsq_pkg::PHASE_COUNT, "phase counter out of range")
	`THSQ_ASSERT_IMPLY(a_latch_last, clk, arst_n, out_valid_q && latch_out_q, last_out_q && dvalid_out_q, "latch without last line byte")
	`THSQ_ASSERT_NEXT(a_read_pending, clk, arst_n, rd_en, pend_s1, "RAM read lost before output")
	`THSQ_ASSERT_IMPLY(a_no_result_overlap, clk, arst_n, single_res, !pend_s1 && !stream_q, "tick result during line stream")

endmodule

`default_nettype wire
